/* design/pcm_mix_pkg.sv */
`default_nettype none

package pcm_mix_pkg;

    localparam int CHANNELS     = 4;
    localparam int CHUNK_FRAMES = 1024;
    localparam int MAX_SAMPLES  = 64;
    localparam int SMEM_AW      = 16;
    localparam int SMEM_DEPTH   = 2 ** SMEM_AW;

    localparam int TAB_AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = $clog2(CHANNELS + 1);
    localparam int FRAME_W = (CHUNK_FRAMES > 1) ? $clog2(CHUNK_FRAMES) : 1;
    localparam int MASK_N  = (CHANNELS < 4) ? CHANNELS : 4;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 17;
    localparam int LEN_W    = 17;
    localparam int GAIN_W   = 7;

    typedef enum logic [1:0] {
        FUNC_DEFINE = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_PLAY   = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    // One channel contribution handed to the accumulator
    typedef struct packed {
        logic              vld;
        logic              mix;
        logic [GAIN_W-1:0] gain;
    } mix_term_t;

endpackage

`default_nettype wire

/* design/pcm_mix_if.sv */
`default_nettype none

interface pcm_mix_cmd_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic        [5:0]  sample_id;
    logic        [15:0] address;
    logic        [16:0] length;
    logic signed [15:0] word_value;
    logic        [7:0]  volume;

    modport source (
        output valid, func, sample_id, address, length, word_value, volume,
        input  ready
    );
    modport sink (
        input  valid, func, sample_id, address, length, word_value, volume,
        output ready
    );
endinterface

interface pcm_mix_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mixed_sample;
    logic               chunk_start;
    logic        [3:0]  active_mask;

    modport source (
        output valid, mixed_sample, chunk_start, active_mask,
        input  ready
    );
    modport sink (
        input  valid, mixed_sample, chunk_start, active_mask,
        output ready
    );
endinterface

`default_nettype wire

/* design/pcm_mix_ram.sv */
`default_nettype none

// Single write port, single read port, registered read data.
module pcm_mix_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/pcm_mix_acc.sv */
`default_nettype none

// Scale one frame by its gain, then add into the running sum with saturation.
module pcm_mix_acc (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   clr,
    input  wire pcm_mix_pkg::mix_term_t term,
    input  wire logic signed [15:0]     value,
    output logic                        busy,
    output logic signed [15:0]          sum
);

    logic               prod_vld_reg;
    logic               prod_mix_reg;
    logic signed [23:0] prod_reg;
    logic signed [23:0] prod_next;
    logic signed [15:0] sum_reg;
    logic signed [15:0] sum_next;
    logic signed [23:0] quot;
    logic signed [16:0] total;

    assign prod_next = 24'(value) * 24'($signed({1'b0, term.gain}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= term.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (term.vld)
        begin
            prod_reg     <= prod_next;
            prod_mix_reg <= term.mix;
        end
        sum_reg <= sum_next;
    end

    // Divide by 128, rounding toward zero
    always_comb
    begin
        quot  = (prod_reg + (prod_reg[23] ? 24'sd127 : 24'sd0)) >>> 7;
        total = 17'(sum_reg) + 17'($signed(quot[15:0]));
        sum_next = sum_reg;
        if (clr)
        begin
            sum_next = '0;
        end
        else if (prod_vld_reg && prod_mix_reg)
        begin
            if (total > 17'sd32767)
            begin
                sum_next = 16'sh7FFF;
            end
            else if (total < -17'sd32768)
            begin
                sum_next = 16'sh8000;
            end
            else
            begin
                sum_next = total[15:0];
            end
        end
    end

    assign busy = prod_vld_reg;
    assign sum  = sum_reg;

endmodule

`default_nettype wire

/* design/pcm_channel_mixer.sv */
`default_nettype none

// Four-channel PCM sample mixer.
//
// cmd channel: one transfer per item. func selects define slot, write one
// sample memory word, play a slot, or tick one output frame. Define, write
// and play finish in the cycle of the transfer; cmd.ready stays high for the
// next item.
// res channel: one transfer per tick carrying the saturated mix, the first
// frame of chunk flag and the mask of channels mixing in the current chunk.
// A tick passes through the channel loop before its result is loaded. The
// loop has per channel one start table read, one sample memory read and two
// accumulator stages, pipelined so that one channel enters per cycle; at the
// first frame of a chunk it is preceded by one pass over the length table,
// again one channel per cycle.
// The result sits in an output register; the next item is taken while it
// waits. A tick that finishes while the previous result is still held waits
// in the final state until res.ready frees the register.
// Reset clears the channel state, the frame counter and the output valid.
// Sample memory and slot tables hold no reset value and must be written
// before they are read.
module pcm_channel_mixer (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pcm_mix_cmd_if.sink   cmd,
    pcm_mix_out_if.source res
);

    localparam int CH      = pcm_mix_pkg::CHANNELS;
    localparam int CHUNK   = pcm_mix_pkg::CHUNK_FRAMES;
    localparam int SMEM_AW = pcm_mix_pkg::SMEM_AW;
    localparam int TAB_AW  = pcm_mix_pkg::TAB_AW;
    localparam int CH_W    = pcm_mix_pkg::CH_W;
    localparam int CNT_W   = pcm_mix_pkg::CNT_W;
    localparam int FRAME_W = pcm_mix_pkg::FRAME_W;
    localparam int POS_W   = pcm_mix_pkg::POS_W;
    localparam int LEN_W   = pcm_mix_pkg::LEN_W;
    localparam int GAIN_W  = pcm_mix_pkg::GAIN_W;
    localparam int MASK_N  = pcm_mix_pkg::MASK_N;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CHK  = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                a_vld_reg, a_vld_next;
    logic [CH_W-1:0]     a_ch_reg, a_ch_next;
    logic                b_vld_reg, b_vld_next;
    logic [CH_W-1:0]     b_ch_reg, b_ch_next;
    logic                first_reg, first_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;

    logic [CH-1:0]       busy_reg, busy_next;
    logic [CH-1:0]       mixing_reg, mixing_next;
    logic [TAB_AW-1:0]   slot_reg [CH];
    logic [TAB_AW-1:0]   slot_next [CH];
    logic [POS_W-1:0]    pos_reg [CH];
    logic [POS_W-1:0]    pos_next [CH];
    logic [GAIN_W-1:0]   gain_reg [CH];
    logic [GAIN_W-1:0]   gain_next [CH];

    logic                ovld_reg, ovld_next;
    logic signed [15:0]  osample_reg, osample_next;
    logic                ostart_reg, ostart_next;
    logic [3:0]          omask_reg, omask_next;

    logic                cmd_xfer;
    logic                id_ok;
    logic                tab_we;
    logic                smp_we;
    logic [TAB_AW-1:0]   tab_raddr;
    logic [15:0]         start_rdata;
    logic [LEN_W-1:0]    len_rdata;
    logic [SMEM_AW-1:0]  smp_raddr;
    logic [15:0]         smp_rdata;
    logic                issue;
    logic                found;
    logic                acc_busy;
    logic signed [15:0]  acc_sum;
    logic                acc_clr;
    pcm_mix_pkg::mix_term_t term;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign id_ok     = (32'(cmd.sample_id) < pcm_mix_pkg::MAX_SAMPLES);
    assign tab_we    = cmd_xfer && (cmd.func == pcm_mix_pkg::FUNC_DEFINE) && id_ok;
    assign smp_we    = cmd_xfer && (cmd.func == pcm_mix_pkg::FUNC_WRITE);
    assign acc_clr   = cmd_xfer && (cmd.func == pcm_mix_pkg::FUNC_TICK);
    assign issue     = (idx_reg < CNT_W'(CH));

    // Both tables are read at the slot of the channel entering the loop.
    // Tables and memory are written only while idle, so reads never overlap
    // a write to the same entry.
    assign tab_raddr = slot_reg[idx_reg[CH_W-1:0]];
    assign smp_raddr = SMEM_AW'(start_rdata) + SMEM_AW'(pos_reg[a_ch_reg])
                     + SMEM_AW'(frame_reg);

    pcm_mix_ram #(.DATA_W(16), .ADDR_W(TAB_AW)) u_start_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (cmd.sample_id[TAB_AW-1:0]),
        .wdata (cmd.address),
        .raddr (tab_raddr),
        .rdata (start_rdata)
    );

    pcm_mix_ram #(.DATA_W(LEN_W), .ADDR_W(TAB_AW)) u_len_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (cmd.sample_id[TAB_AW-1:0]),
        .wdata (cmd.length),
        .raddr (tab_raddr),
        .rdata (len_rdata)
    );

    pcm_mix_ram #(.DATA_W(16), .ADDR_W(SMEM_AW)) u_smp_mem (
        .clk   (clk),
        .we    (smp_we),
        .waddr (SMEM_AW'(cmd.address)),
        .wdata (cmd.word_value),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    // Sample data of channel b arrives now; hand it to the accumulator
    always_comb
    begin
        term.vld  = b_vld_reg;
        term.mix  = mixing_reg[b_ch_reg];
        term.gain = gain_reg[b_ch_reg];
    end

    pcm_mix_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (acc_clr),
        .term  (term),
        .value ($signed(smp_rdata)),
        .busy  (acc_busy),
        .sum   (acc_sum)
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        a_vld_next   = 1'b0;
        a_ch_next    = a_ch_reg;
        b_vld_next   = 1'b0;
        b_ch_next    = b_ch_reg;
        first_next   = first_reg;
        frame_next   = frame_reg;
        busy_next    = busy_reg;
        mixing_next  = mixing_reg;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        gain_next    = gain_reg;
        ovld_next    = ovld_reg;
        osample_next = osample_reg;
        ostart_next  = ostart_reg;
        omask_next   = omask_reg;
        found        = 1'b0;

        if (res.valid && res.ready)
        begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer && (cmd.func == pcm_mix_pkg::FUNC_PLAY) && id_ok)
                begin
                    // Take the lowest free channel; drop the request if none
                    for (int c = 0; c < CH; c++)
                    begin
                        if (!found && !busy_reg[c])
                        begin
                            found          = 1'b1;
                            busy_next[c]   = 1'b1;
                            mixing_next[c] = 1'b0;
                            slot_next[c]   = cmd.sample_id[TAB_AW-1:0];
                            pos_next[c]    = '0;
                            gain_next[c]   = cmd.volume[7:1];
                        end
                    end
                end
                if (cmd_xfer && (cmd.func == pcm_mix_pkg::FUNC_TICK))
                begin
                    first_next = (frame_reg == '0);
                    idx_next   = '0;
                    state_next = (frame_reg == '0) ? ST_CHK : ST_MIX;
                end
            end

            ST_CHK:
            begin
                // Issue length reads, one channel a cycle
                if (issue)
                begin
                    a_vld_next = 1'b1;
                    a_ch_next  = idx_reg[CH_W-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
                // End or admit the channel whose length is back
                if (a_vld_reg)
                begin
                    mixing_next[a_ch_reg] = 1'b0;
                    if (busy_reg[a_ch_reg])
                    begin
                        if ((18'(pos_reg[a_ch_reg]) + 18'(CHUNK)) >= 18'(len_rdata))
                        begin
                            busy_next[a_ch_reg] = 1'b0;
                        end
                        else
                        begin
                            mixing_next[a_ch_reg] = 1'b1;
                        end
                    end
                end
                if (!issue && !a_vld_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_MIX;
                end
            end

            ST_MIX:
            begin
                if (issue)
                begin
                    a_vld_next = 1'b1;
                    a_ch_next  = idx_reg[CH_W-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
                if (a_vld_reg)
                begin
                    b_vld_next = 1'b1;
                    b_ch_next  = a_ch_reg;
                end
                if (!issue && !a_vld_reg && !b_vld_reg && !acc_busy)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                // Hold until the output register is free
                if (!ovld_reg || res.ready)
                begin
                    ovld_next    = 1'b1;
                    osample_next = acc_sum;
                    ostart_next  = first_reg;
                    omask_next   = '0;
                    for (int c = 0; c < MASK_N; c++)
                    begin
                        omask_next[c] = mixing_reg[c];
                    end
                    if (frame_reg == FRAME_W'(CHUNK - 1))
                    begin
                        frame_next = '0;
                        for (int c = 0; c < CH; c++)
                        begin
                            if (mixing_reg[c])
                            begin
                                pos_next[c] = pos_reg[c] + POS_W'(CHUNK);
                            end
                        end
                    end
                    else
                    begin
                        frame_next = frame_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            first_reg  <= 1'b0;
            frame_reg  <= '0;
            busy_reg   <= '0;
            mixing_reg <= '0;
            ovld_reg   <= 1'b0;
            for (int c = 0; c < CH; c++)
            begin
                slot_reg[c] <= '0;
                pos_reg[c]  <= '0;
                gain_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            a_vld_reg  <= a_vld_next;
            b_vld_reg  <= b_vld_next;
            first_reg  <= first_next;
            frame_reg  <= frame_next;
            busy_reg   <= busy_next;
            mixing_reg <= mixing_next;
            ovld_reg   <= ovld_next;
            slot_reg   <= slot_next;
            pos_reg    <= pos_next;
            gain_reg   <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ch_reg    <= a_ch_next;
        b_ch_reg    <= b_ch_next;
        osample_reg <= osample_next;
        ostart_reg  <= ostart_next;
        omask_reg   <= omask_next;
    end

    assign res.valid        = ovld_reg;
    assign res.mixed_sample = osample_reg;
    assign res.chunk_start  = ostart_reg;
    assign res.active_mask  = omask_reg;

    // A channel only mixes while it is busy
    a_mix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mixing_reg & ~busy_reg) == '0)
        else $error("channel mixing while not busy");

    // The channel loop is drained before a result is loaded
    a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (!a_vld_reg && !b_vld_reg && !acc_busy))
        else $error("result loaded with channel loop still active");

    // No table or memory write while a tick is in progress
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (!tab_we && !smp_we))
        else $error("storage write during tick");

    // Frame counter stays inside the chunk
    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(frame_reg) < CHUNK)
        else $error("frame counter out of range");

endmodule

`default_nettype wire

/* tb/pcm_channel_mixer_test.sv */
`timescale 1ns / 100ps

module pcm_channel_mixer_test;

    localparam int CHANNELS     = pcm_mix_pkg::CHANNELS;
    localparam int CHUNK_FRAMES = pcm_mix_pkg::CHUNK_FRAMES;
    localparam int MAX_SAMPLES  = pcm_mix_pkg::MAX_SAMPLES;
    localparam int SMEM_DEPTH   = pcm_mix_pkg::SMEM_DEPTH;
    localparam int TAB_AW       = pcm_mix_pkg::TAB_AW;
    localparam int POS_W        = pcm_mix_pkg::POS_W;
    localparam int LEN_W        = pcm_mix_pkg::LEN_W;
    localparam int GAIN_W       = pcm_mix_pkg::GAIN_W;

    // Stimulus plan
    //
    // The only words ever read are those of one written window of sample memory. The
    // window runs from WIN_BASE across the top of the address space and wraps to
    // the bottom, so the modulo wrap of the read address is exercised. The run
    // ticks at most READ_REACH frames, all inside the first chunk, so a channel
    // reads at most READ_REACH words past its start. Every slot start offset o,
    // whatever the length, satisfies o + READ_REACH < WIN_WORDS. A slot that is
    // redefined while a channel plays it therefore stays inside the window as well.
    localparam int WIN_BASE    = 65504;
    localparam int WIN_WORDS   = 320;
    localparam int READ_REACH  = 256;
    localparam int TICK_BUDGET = READ_REACH;
    localparam int CALM_TICKS  = 40;

    typedef struct packed {
        pcm_mix_pkg::func_t func;
        logic [5:0]        sample_id;
        logic [15:0]       address;
        logic [LEN_W-1:0]  length;
        logic [15:0]       word_value;
        logic [7:0]        volume;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] mixed;
        logic        first;
        logic [3:0]  mask;
    } frame_t;

    // Predict the mixer and check each output transfer against the predicted
    // frames, oldest first.
    class mix_scoreboard;
        logic signed [15:0]  sample_words [SMEM_DEPTH];
        logic [15:0]         slot_start [MAX_SAMPLES];
        logic [LEN_W-1:0]    slot_len [MAX_SAMPLES];
        bit                  ch_busy [CHANNELS];
        bit                  ch_mixing [CHANNELS];
        logic [TAB_AW-1:0]   ch_slot [CHANNELS];
        logic [POS_W-1:0]    ch_pos [CHANNELS];
        logic [GAIN_W-1:0]   ch_gain [CHANNELS];
        int                  frame_idx;
        frame_t              pending_frames [$];
        int                  error_count;
        int                  frames_checked;
        int                  chunk_starts;
        int                  clamped_frames;
        int                  plays_started;
        int                  plays_dropped;

        function new();
            foreach (ch_slot[c])
            begin
                ch_slot[c] = '0;
                ch_pos[c]  = '0;
                ch_gain[c] = '0;
            end
            frame_idx = 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at frame %0d: %s got %0d, expected %0d",
                     frames_checked, what, got, want);
            error_count++;
        endtask

        function void note_command(cmd_item_t item);
            int                 c;
            int                 sum;
            int                 v;
            bit                 first;
            bit                 placed;
            bit                 clamped;
            logic [3:0]         mask;
            logic [15:0]        rd_addr;
            frame_t             want;
            case (item.func)
                pcm_mix_pkg::FUNC_DEFINE:
                begin
                    if (item.sample_id < MAX_SAMPLES)
                    begin
                        slot_start[item.sample_id] = item.address;
                        slot_len[item.sample_id]   = item.length;
                    end
                end
                pcm_mix_pkg::FUNC_WRITE:
                begin
                    sample_words[item.address] = item.word_value;
                end
                pcm_mix_pkg::FUNC_PLAY:
                begin
                    placed = 1'b0;
                    if (item.sample_id < MAX_SAMPLES)
                    begin
                        for (c = 0; c < CHANNELS; c++)
                        begin
                            if (!placed && !ch_busy[c])
                            begin
                                ch_busy[c]   = 1'b1;
                                ch_mixing[c] = 1'b0;
                                ch_slot[c]   = item.sample_id;
                                ch_pos[c]    = '0;
                                ch_gain[c]   = GAIN_W'((int'(item.volume) * 128) >> 8);
                                placed       = 1'b1;
                            end
                        end
                        if (placed)
                            plays_started++;
                        else
                            plays_dropped++;
                    end
                end
                default:
                begin
                    first = (frame_idx == 0);
                    if (first)
                    begin
                        chunk_starts++;
                        for (c = 0; c < CHANNELS; c++)
                        begin
                            ch_mixing[c] = 1'b0;
                            if (ch_busy[c])
                            begin
                                if (int'(ch_pos[c]) + CHUNK_FRAMES >= int'(slot_len[ch_slot[c]]))
                                    ch_busy[c] = 1'b0;
                                else
                                    ch_mixing[c] = 1'b1;
                            end
                        end
                    end
                    sum     = 0;
                    mask    = '0;
                    clamped = 1'b0;
                    for (c = 0; c < CHANNELS; c++)
                    begin
                        if (ch_mixing[c])
                        begin
                            rd_addr = 16'(int'(slot_start[ch_slot[c]]) + int'(ch_pos[c])
                                          + frame_idx);
                            v   = sample_words[rd_addr];
                            // Integer division truncates toward zero, as the block must.
                            sum = sum + (v * int'(ch_gain[c])) / 128;
                            if (sum > 32767)
                            begin
                                sum     = 32767;
                                clamped = 1'b1;
                            end
                            else if (sum < -32768)
                            begin
                                sum     = -32768;
                                clamped = 1'b1;
                            end
                            if (c < 4)
                                mask[c] = 1'b1;
                        end
                    end
                    frame_idx++;
                    if (frame_idx >= CHUNK_FRAMES)
                    begin
                        frame_idx = 0;
                        for (c = 0; c < CHANNELS; c++)
                            if (ch_mixing[c])
                                ch_pos[c] = ch_pos[c] + CHUNK_FRAMES;
                    end
                    if (clamped)
                        clamped_frames++;
                    want.mixed = 16'(sum);
                    want.first = first;
                    want.mask  = mask;
                    pending_frames.push_back(want);
                end
            endcase
        endfunction

        task check_frame(logic [15:0] mixed, logic first, logic [3:0] mask);
            frame_t want;
            if (pending_frames.size() == 0)
            begin
                report_mismatch("unexpected frame, mixed_sample", $signed(mixed), 0);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (mixed !== want.mixed)
                    report_mismatch("mixed_sample", $signed(mixed), $signed(want.mixed));
                if (first !== want.first)
                    report_mismatch("chunk_start", first, want.first);
                if (mask !== want.mask)
                    report_mismatch("active_mask", mask, want.mask);
            end
            frames_checked++;
        endtask
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    bit            calm;
    int            ticks_sent;
    int            res_stall;
    mix_scoreboard sb;

    pcm_mix_cmd_if cmd_bus ();
    pcm_mix_out_if res_bus ();

    pcm_channel_mixer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Fill every field at random, so that the unused fields of each item change
    // too. Then set the fields that the operation uses.
    function automatic cmd_item_t random_fields(pcm_mix_pkg::func_t f);
        cmd_item_t item;
        item.func       = f;
        item.sample_id  = 6'($urandom);
        item.address    = 16'($urandom);
        item.length     = LEN_W'($urandom);
        item.word_value = 16'($urandom);
        item.volume     = 8'($urandom);
        return item;
    endfunction

    function automatic cmd_item_t write_item(logic [15:0] addr, logic [15:0] value);
        cmd_item_t item;
        item            = random_fields(pcm_mix_pkg::FUNC_WRITE);
        item.address    = addr;
        item.word_value = value;
        return item;
    endfunction

    function automatic cmd_item_t define_item(int id, int start_off, int len);
        cmd_item_t item;
        item           = random_fields(pcm_mix_pkg::FUNC_DEFINE);
        item.sample_id = 6'(id);
        item.address   = 16'(WIN_BASE + start_off);
        item.length    = LEN_W'(len);
        return item;
    endfunction

    function automatic cmd_item_t play_item(int id, int vol);
        cmd_item_t item;
        item           = random_fields(pcm_mix_pkg::FUNC_PLAY);
        item.sample_id = 6'(id);
        item.volume    = 8'(vol);
        return item;
    endfunction

    // Mix lengths that end at the chunk start with ones that keep playing.
    function automatic cmd_item_t random_define(int id);
        int len;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            len = $urandom_range(0, 2048);
        else if (pick < 8)
            len = $urandom_range(CHUNK_FRAMES + 1, 5000);
        else
            len = $urandom_range(0, 65536);
        return define_item(id, $urandom_range(0, WIN_WORDS - 1 - READ_REACH), len);
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive one item and hold it until the transfer. At random, insert an idle
    // burst first, except near the end of the run. On return the clock edge of the
    // transfer has passed and valid is still high, so the next call either
    // drives the next item or drops valid. Valid is never assigned twice in
    // one time step.
    task automatic send_command(input cmd_item_t item);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.func       <= item.func;
        cmd_bus.sample_id  <= item.sample_id;
        cmd_bus.address    <= item.address;
        cmd_bus.length     <= item.length;
        cmd_bus.word_value <= item.word_value;
        cmd_bus.volume     <= item.volume;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        sb.note_command(item);
        if (item.func == pcm_mix_pkg::FUNC_TICK)
            ticks_sent++;
    endtask

    // Result side: check each transfer, then drive ready for the next edge.
    // Stall in random bursts, but never near the end of the run.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_frame(res_bus.mixed_sample, res_bus.chunk_start, res_bus.active_mask);
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else if (res_stall > 0)
        begin
            res_bus.ready <= 1'b0;
            res_stall--;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                res_stall = $urandom_range(1, 16);
        end
    end

    initial
    begin
        int k;
        int pick;
        sb                 = new();
        calm               = 1'b0;
        ticks_sent         = 0;
        res_stall          = 0;
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.func       = pcm_mix_pkg::FUNC_DEFINE;
        cmd_bus.sample_id  = '0;
        cmd_bus.address    = '0;
        cmd_bus.length     = '0;
        cmd_bus.word_value = '0;
        cmd_bus.volume     = '0;
        res_bus.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write the whole read window and define every slot before the first
        // tick. This includes slot 0, which idle channels point at after reset.
        for (k = 0; k < WIN_WORDS; k++)
            send_command(write_item(16'(WIN_BASE + k), random_word()));
        for (k = 0; k < MAX_SAMPLES; k++)
            send_command(random_define(k));

        // Directed part. Put full scale at both ends of the address space.
        send_command(write_item(16'hFFFF, 16'h7FFF));
        send_command(write_item(16'h0000, 16'h8000));
        // Zero length, exactly one chunk, one chunk plus one frame starting at
        // the top word (its reads wrap to address 0), and the longest length.
        send_command(define_item(0, 0, 0));
        send_command(define_item(2, 50, CHUNK_FRAMES));
        send_command(define_item(1, 31, CHUNK_FRAMES + 1));
        send_command(define_item(MAX_SAMPLES - 1, 0, 65536));
        // Fill all four channels, then drop a fifth play. Cover the volume
        // extremes and an odd volume that loses its low bit.
        send_command(play_item(MAX_SAMPLES - 1, 255));
        send_command(play_item(0, 0));
        send_command(play_item(1, 1));
        send_command(play_item(2, 129));
        send_command(play_item(1, 200));
        // First frame of a chunk: zero length and exactly one chunk end here
        // without sounding.
        send_command(random_fields(pcm_mix_pkg::FUNC_TICK));
        send_command(random_fields(pcm_mix_pkg::FUNC_TICK));
        // Play in the middle of a chunk: the channel stays out of the mix for
        // the rest of the chunk.
        send_command(play_item(1, 255));
        send_command(play_item(MAX_SAMPLES - 1, 254));
        send_command(random_fields(pcm_mix_pkg::FUNC_TICK));
        send_command(random_fields(pcm_mix_pkg::FUNC_TICK));

        // Random part: mostly ticks, all inside the first chunk.
        // About one item in eight is a define, write or play.
        while (ticks_sent < TICK_BUDGET)
        begin
            calm = (ticks_sent >= TICK_BUDGET - CALM_TICKS);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_command(random_define($urandom_range(0, MAX_SAMPLES - 1)));
            else if (pick < 8)
                send_command(write_item(16'($urandom), random_word()));
            else if (pick < 13)
                send_command(play_item($urandom_range(0, MAX_SAMPLES - 1),
                                       ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 255)));
            else
                send_command(random_fields(pcm_mix_pkg::FUNC_TICK));
        end
        cmd_bus.valid <= 1'b0;

        // Drain the remaining frames, then watch for stray results.
        while (sb.pending_frames.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        $display("run covered %0d frames across %0d chunk starts, %0d of them clamped",
                 sb.frames_checked, sb.chunk_starts, sb.clamped_frames);
        $display("plays started %0d, dropped with every channel busy %0d",
                 sb.plays_started, sb.plays_dropped);
        if (sb.error_count == 0)
            $display("pcm_channel_mixer_test: clean");
        else
            $display("pcm_channel_mixer_test: errors");
        $finish;
    end

    // Ends the run if the block hangs; a clean run takes a small fraction of this.
    initial
    begin
        #3_000_000;
        $display("timeout with %0d frames still expected", sb.pending_frames.size());
        $display("pcm_channel_mixer_test: errors");
        $finish;
    end

endmodule
